// ----- hw/rtl/shl_pkg.sv -----
`timescale 1ns / 1ps
package shl_pkg;

   localparam int unsigned ELEM_W  = 16;
   localparam int unsigned DOT_W   = 40;
   localparam int unsigned GRAD_W  = 40;
   localparam int unsigned INDEX_W = 6;
   localparam int unsigned LOSS_W  = 48;

   typedef struct packed {
      logic accept;
      logic accumulate;
      logic margin;
      logic sq_hh;
      logic sq_hl;
      logic sq_ll;
      logic sq_sum;
      logic loss_update;
      logic mult;
      logic form;
      logic item_end;
   } shl_cmd_type;

   typedef struct packed {
      logic last_element;
      logic final_gradient;
   } shl_status_type;

endpackage

// ----- hw/rtl/shl_req_if.sv -----
`timescale 1ns / 1ps
interface shl_req_if;
   import shl_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [ELEM_W-1:0] actual;
   logic signed [ELEM_W-1:0] expected;
   logic                     last_element;
   logic                     last_batch_item;

   modport source (
      output valid, actual, expected, last_element, last_batch_item,
      input  ready
   );

   modport sink (
      input  valid, actual, expected, last_element, last_batch_item,
      output ready
   );

endinterface

// ----- hw/rtl/shl_rsp_if.sv -----
`timescale 1ns / 1ps
interface shl_rsp_if;
   import shl_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [GRAD_W-1:0] gradient;
   logic [INDEX_W-1:0]       element_index;
   logic                     last_of_item;
   logic [LOSS_W-1:0]        batch_loss;
   logic                     batch_done;
   logic                     overflow;

   modport source (
      output valid, gradient, element_index, last_of_item, batch_loss, batch_done,
             overflow,
      input  ready
   );

   modport sink (
      input  valid, gradient, element_index, last_of_item, batch_loss, batch_done,
             overflow,
      output ready
   );

endinterface

// ----- hw/rtl/shl_datapath.sv -----
`timescale 1ns / 1ps
module shl_datapath #(
   parameter int unsigned ITEM_SIZE = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  shl_pkg::shl_cmd_type              cmd,
   output shl_pkg::shl_status_type           status,
   input  logic signed [shl_pkg::ELEM_W-1:0] req_actual,
   input  logic signed [shl_pkg::ELEM_W-1:0] req_expected,
   input  logic                              req_last_element,
   input  logic                              req_last_batch_item,
   output logic signed [shl_pkg::GRAD_W-1:0] rsp_gradient,
   output logic [shl_pkg::INDEX_W-1:0]       rsp_element_index,
   output logic                              rsp_last_of_item,
   output logic [shl_pkg::LOSS_W-1:0]        rsp_batch_loss,
   output logic                              rsp_batch_done,
   output logic                              rsp_overflow
);
   import shl_pkg::*;

   localparam int unsigned AW = (ITEM_SIZE > 1) ? $clog2(ITEM_SIZE) : 1;
   localparam int unsigned CW = $clog2(ITEM_SIZE + 1);
   localparam logic [CW-1:0] ITEM_MAX = CW'(ITEM_SIZE);

   localparam logic signed [DOT_W-1:0] DOT_MAX = 40'sh7F_FFFF_FFFF;
   localparam logic signed [DOT_W-1:0] DOT_MIN = 40'sh80_0000_0000;
   localparam logic signed [DOT_W-1:0] ONE_Q24 = 40'sd16777216;
   localparam logic signed [DOT_W:0]   ONE_Q24_EXT = 41'sd16777216;
   localparam logic signed [DOT_W:0]   SQ_LIMIT = 41'sh10_0000_0000;
   localparam logic [LOSS_W-1:0]       LOSS_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [45:0]             GRAD_NEG_LIM = 46'h80_0000_0000;
   localparam logic [45:0]             GRAD_POS_LIM = 46'h7F_FFFF_FFFF;

   logic signed [ELEM_W-1:0] store_mem [2**AW];

   logic [CW-1:0]            count_ff,   count_in;
   logic                     dropped_ff, dropped_in;
   logic                     last_ff;
   logic                     batch_end_ff;
   logic signed [31:0]       prod_ff;
   logic signed [DOT_W-1:0]  dot_ff,     dot_in;
   logic [DOT_W:0]           m_ff;
   logic                     active_ff;
   logic                     big_ff;
   logic [47:0]              sq_prod_ff;
   logic [71:0]              sq_acc_ff;
   logic [LOSS_W-1:0]        loss_ff,    loss_in;
   logic [CW-1:0]            rd_ptr_ff,  rd_ptr_in;
   logic signed [ELEM_W-1:0] rdata_ff;
   logic [45:0]              mag_ff;
   logic                     neg_ff;
   logic                     zero_ff;
   logic [CW-1:0]            idx_ff;
   logic signed [GRAD_W-1:0] grad_ff;
   logic [INDEX_W-1:0]       index_ff;
   logic                     final_ff;
   logic [LOSS_W-1:0]        rsp_loss_ff;
   logic                     done_ff;
   logic                     ovf_ff;

   logic                     full;
   logic signed [31:0]       elem_prod;
   logic signed [DOT_W:0]    dot_sum;
   logic signed [DOT_W:0]    margin;
   logic [23:0]              sq_hi;
   logic [23:0]              sq_lo;
   logic [23:0]              sq_op_a;
   logic [23:0]              sq_op_b;
   logic [47:0]              sq_mul;
   logic [LOSS_W-1:0]        loss_term;
   logic [LOSS_W:0]          loss_sum;
   logic [ELEM_W-1:0]        emag;
   logic [56:0]              grad_mul;
   logic signed [GRAD_W-1:0] grad_val;

   assign full      = (count_ff == ITEM_MAX);
   assign elem_prod = req_actual * req_expected;

   assign dot_sum = {dot_ff[DOT_W-1], dot_ff} + {{9{prod_ff[31]}}, prod_ff};
   assign margin  = ONE_Q24_EXT - {dot_ff[DOT_W-1], dot_ff};

   assign sq_hi   = m_ff[35:12];
   assign sq_lo   = {12'd0, m_ff[11:0]};
   assign sq_op_a = cmd.sq_ll ? sq_lo : sq_hi;
   assign sq_op_b = cmd.sq_hh ? sq_hi : sq_lo;
   assign sq_mul  = sq_op_a * sq_op_b;

   assign loss_term = big_ff ? LOSS_MAX : sq_acc_ff[71:24];
   assign loss_sum  = {1'b0, loss_ff} + {1'b0, loss_term};

   assign emag     = rdata_ff[ELEM_W-1] ? (~rdata_ff + 16'd1) : rdata_ff;
   assign grad_mul = 57'(m_ff) * 57'(emag);

   always_comb begin
      if (zero_ff) begin
         grad_val = '0;
      end else if (neg_ff) begin
         grad_val = (mag_ff > GRAD_NEG_LIM) ? DOT_MIN : 40'(~mag_ff + 46'd1);
      end else begin
         grad_val = (mag_ff > GRAD_POS_LIM) ? DOT_MAX : mag_ff[39:0];
      end
   end

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      dot_in     = dot_ff;
      loss_in    = loss_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (cmd.accept) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.accumulate) begin
         if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
            dot_in = dot_sum[DOT_W] ? DOT_MIN : DOT_MAX;
         end else begin
            dot_in = dot_sum[DOT_W-1:0];
         end
      end
      if (cmd.margin) begin
         rd_ptr_in = '0;
      end
      if (cmd.loss_update && active_ff) begin
         loss_in = loss_sum[LOSS_W] ? LOSS_MAX : loss_sum[LOSS_W-1:0];
      end
      if (cmd.mult) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (cmd.item_end) begin
         count_in   = '0;
         dropped_in = 1'b0;
         dot_in     = '0;
         rd_ptr_in  = '0;
         if (batch_end_ff) begin
            loss_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         dot_ff     <= '0;
         loss_ff    <= '0;
         rd_ptr_ff  <= '0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         dot_ff     <= dot_in;
         loss_ff    <= loss_in;
         rd_ptr_ff  <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && !full) begin
         store_mem[count_ff[AW-1:0]] <= req_expected;
      end
      rdata_ff <= store_mem[rd_ptr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         last_ff      <= req_last_element;
         batch_end_ff <= req_last_batch_item;
         prod_ff      <= full ? 32'sd0 : elem_prod;
      end
      if (cmd.margin) begin
         active_ff <= (dot_ff < ONE_Q24);
         big_ff    <= (margin >= SQ_LIMIT);
         m_ff      <= (dot_ff < ONE_Q24) ? margin : '0;
      end
      if (cmd.sq_hh || cmd.sq_hl || cmd.sq_ll) begin
         sq_prod_ff <= sq_mul;
      end
      if (cmd.sq_hl) begin
         sq_acc_ff <= {sq_prod_ff, 24'd0};
      end else if (cmd.sq_ll) begin
         sq_acc_ff <= sq_acc_ff + (72'(sq_prod_ff) << 13);
      end else if (cmd.sq_sum) begin
         sq_acc_ff <= sq_acc_ff + 72'(sq_prod_ff);
      end
      if (cmd.mult) begin
         mag_ff  <= grad_mul[56:11];
         neg_ff  <= !rdata_ff[ELEM_W-1];
         zero_ff <= (rdata_ff == '0);
         idx_ff  <= rd_ptr_ff;
      end
      if (cmd.form) begin
         grad_ff     <= grad_val;
         index_ff    <= INDEX_W'(idx_ff);
         final_ff    <= ((idx_ff + 1'b1) == count_ff);
         rsp_loss_ff <= loss_ff;
         done_ff     <= ((idx_ff + 1'b1) == count_ff) && batch_end_ff;
         ovf_ff      <= dropped_ff;
      end
   end

   assign status.last_element   = last_ff;
   assign status.final_gradient = final_ff;

   assign rsp_gradient      = grad_ff;
   assign rsp_element_index = index_ff;
   assign rsp_last_of_item  = final_ff;
   assign rsp_batch_loss    = rsp_loss_ff;
   assign rsp_batch_done    = done_ff;
   assign rsp_overflow      = ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ITEM_MAX)
      else $error("element count beyond capacity");

   a_item_end_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.item_end |=> (count_ff == '0 && dot_ff == '0 && !dropped_ff))
      else $error("item state not cleared");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mult |-> (rd_ptr_ff < count_ff))
      else $error("gradient read beyond stored elements");

endmodule

// ----- hw/rtl/shl_ctrl.sv -----
`timescale 1ns / 1ps
module shl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  shl_pkg::shl_status_type status,
   output shl_pkg::shl_cmd_type    cmd
);
   import shl_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_ACCUM  = 11'b000_0000_0010,
      ST_MARGIN = 11'b000_0000_0100,
      ST_SQ_HH  = 11'b000_0000_1000,
      ST_SQ_HL  = 11'b000_0001_0000,
      ST_SQ_LL  = 11'b000_0010_0000,
      ST_SQ_SUM = 11'b000_0100_0000,
      ST_LOSS   = 11'b000_1000_0000,
      ST_MULT   = 11'b001_0000_0000,
      ST_FORM   = 11'b010_0000_0000,
      ST_SEND   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.accumulate = 1'b1;
            state_in = status.last_element ? ST_MARGIN : ST_IDLE;
         end
         ST_MARGIN: begin
            cmd.margin = 1'b1;
            state_in   = ST_SQ_HH;
         end
         ST_SQ_HH: begin
            cmd.sq_hh = 1'b1;
            state_in  = ST_SQ_HL;
         end
         ST_SQ_HL: begin
            cmd.sq_hl = 1'b1;
            state_in  = ST_SQ_LL;
         end
         ST_SQ_LL: begin
            cmd.sq_ll = 1'b1;
            state_in  = ST_SQ_SUM;
         end
         ST_SQ_SUM: begin
            cmd.sq_sum = 1'b1;
            state_in   = ST_LOSS;
         end
         ST_LOSS: begin
            cmd.loss_update = 1'b1;
            state_in        = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_FORM;
         end
         ST_FORM: begin
            cmd.form = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.final_gradient) begin
                  cmd.item_end = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_MULT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result sides open together");

   a_final_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && status.final_gradient) |=> req_ready)
      else $error("no return to input after final gradient");

   a_valid_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_item_end_on_transfer: assert property (@(posedge clock) disable iff (reset)
      cmd.item_end |-> (rsp_valid && rsp_ready && status.final_gradient))
      else $error("item closed without final transfer");

endmodule

// ----- hw/rtl/squared_hinge_loss_gradient.sv -----
`timescale 1ns / 1ps
// Squared hinge loss and gradient over batch items of signed Q4.12 elements.
// req_port: one (actual, expected) pair per transfer; last_element closes a
//   batch item, last_batch_item on that pair closes the batch.
// rsp_port: one gradient per stored element of the item, in element order,
//   each carrying the running batch loss; batch_done marks the batch total.
// Up to ITEM_SIZE elements are stored per item; extra ones are dropped and
//   flag overflow on every result of that item.
// A middle element is accepted, then added into the saturating dot product,
//   before the next one is taken. After the last element the margin and loss
//   are formed (the squared margin runs through one 24x24 multiplier in
//   three passes), then each gradient goes through store read, 41x16
//   multiply and saturate into the result register, plus any stall.
// req_port.ready is high only while idle, between elements and items; no
//   input is taken while an item's gradients are being sent.
// When the receiver stalls, the result is held stable until transferred.
// Reset clears the element count, dot product, batch loss and overflow flag.
module squared_hinge_loss_gradient #(
   parameter int unsigned ITEM_SIZE = 16
) (
   input  logic     clock,
   input  logic     reset,
   shl_req_if.sink  req_port,
   shl_rsp_if.source rsp_port
);
   import shl_pkg::*;

   shl_cmd_type    cmd;
   shl_status_type status;

   shl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   shl_datapath #(
      .ITEM_SIZE (ITEM_SIZE)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_actual          (req_port.actual),
      .req_expected        (req_port.expected),
      .req_last_element    (req_port.last_element),
      .req_last_batch_item (req_port.last_batch_item),
      .rsp_gradient        (rsp_port.gradient),
      .rsp_element_index   (rsp_port.element_index),
      .rsp_last_of_item    (rsp_port.last_of_item),
      .rsp_batch_loss      (rsp_port.batch_loss),
      .rsp_batch_done      (rsp_port.batch_done),
      .rsp_overflow        (rsp_port.overflow)
   );

endmodule
